@@ sv/nep_pkg.sv @@
// Package for the neighbor eviction policy block.
// Holds field widths, request codes and the table-size constants.
// No dependencies.
package nep_pkg;

    // Table size and rank limit of the neighbor table
    localparam int MAX_NEIGHBORS       = 16;
    localparam int INFINITE_RANK_VALUE = 65535;

    // Field widths
    localparam int REQ_W   = 2;
    localparam int ID_W    = 4;
    localparam int RANK_W  = 16;
    localparam int COUNT_W = 5;

    // Width used to compare the child count against the table caps
    localparam int CAP_W = 9;

    typedef logic [ID_W-1:0]    t_id;
    typedef logic [RANK_W-1:0]  t_rank;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [CAP_W-1:0]   t_cap;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ENTRY = 2'd0,
        REQ_DIS   = 2'd1,
        REQ_DIO   = 2'd2,
        REQ_DAO   = 2'd3
    } t_req;

    localparam t_rank  INF_RANK     = RANK_W'(INFINITE_RANK_VALUE);
    localparam t_rank  INC_RESET    = 16'd256;
    localparam t_cap   CAP_NON_ROOT = CAP_W'(MAX_NEIGHBORS - 2);
    localparam t_cap   CAP_ROOT     = CAP_W'(MAX_NEIGHBORS);
    localparam t_count COUNT_SAT    = '1;

endpackage

@@ sv/nep_in_if.sv @@
// Input channel of the neighbor eviction policy: valid, ready and one item.
// Depends on nep_pkg for field types.
interface nep_in_if;
    import nep_pkg::*;

    logic  valid;
    logic  ready;
    t_req  req_type;
    t_id   neighbor_id;
    logic  is_next_hop;
    logic  is_parent;
    logic  is_preferred;
    logic  parent_rank_usable;
    t_rank path_rank;
    t_rank new_rank;
    logic  instance_known;
    logic  node_is_root;

    modport source (
        output valid, req_type, neighbor_id, is_next_hop, is_parent, is_preferred,
               parent_rank_usable, path_rank, new_rank, instance_known, node_is_root,
        input  ready
    );

    modport sink (
        input  valid, req_type, neighbor_id, is_next_hop, is_parent, is_preferred,
               parent_rank_usable, path_rank, new_rank, instance_known, node_is_root,
        output ready
    );
endinterface

@@ sv/nep_out_if.sv @@
// Result channel of the neighbor eviction policy: valid, ready and one item.
// Depends on nep_pkg for field types.
interface nep_out_if;
    import nep_pkg::*;

    logic   valid;
    logic   ready;
    logic   victim_found;
    t_id    victim_id;
    t_count children_seen;

    modport source (
        output valid, victim_found, victim_id, children_seen,
        input  ready
    );

    modport sink (
        input  valid, victim_found, victim_id, children_seen,
        output ready
    );
endinterface

@@ sv/neighbor_eviction_policy.sv @@
// Neighbor eviction policy: scan state, decision logic and result register.
// Depends on nep_pkg, nep_in_if and nep_out_if.
// A decision item's result is registered and shows on the output in the cycle after acceptance.
// Throughput: one item per cycle; the result register stalls input only
// while it holds a result the sink has not taken.
// Reset (synchronous, active low) clears the scan state and the result
// valid flag and sets min_hop_rank_increase to 256.
module neighbor_eviction_policy (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  nep_pkg::t_rank      i_cfg_wdata,
    nep_in_if.sink              i_in,
    nep_out_if.source           o_out
);
    import nep_pkg::*;

    // Configuration and scan state
    t_rank  r_inc;
    t_rank  r_worst,     n_worst;
    t_id    r_slot,      n_slot;
    logic   r_cand_valid, n_cand_valid;
    t_count r_child_cnt, n_child_cnt;

    // Result register
    logic   r_out_valid;
    logic   r_victim_found, n_victim_found;
    t_id    r_victim_id,    n_victim_id;
    t_count r_children,     n_children;

    logic                in_acc;
    logic                is_dec;
    logic                allow;
    logic [RANK_W+1:0]   dio_lhs;
    t_cap                cnt_ext;

    // Accept while the result register is empty or being drained
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;
    assign is_dec     = (i_in.req_type != REQ_ENTRY);

    // new_rank + inc < worst - inc/2, rearranged so no side goes negative
    assign dio_lhs = {2'b00, i_in.new_rank} + {2'b00, r_inc} + {3'b000, r_inc[RANK_W-1:1]};
    assign cnt_ext = {{(CAP_W-COUNT_W){1'b0}}, r_child_cnt};

    // Decide whether the candidate may go
    always_comb begin
        case (i_in.req_type)
            REQ_DIS: allow = (cnt_ext < CAP_NON_ROOT);
            REQ_DIO: allow = i_in.instance_known && (dio_lhs < {2'b00, r_worst});
            REQ_DAO: allow = (cnt_ext < (i_in.node_is_root ? CAP_ROOT : CAP_NON_ROOT));
            default: allow = 1'b0;
        endcase
    end

    // Advance the scan state on entries, clear it on decisions
    always_comb begin
        n_worst      = r_worst;
        n_slot       = r_slot;
        n_cand_valid = r_cand_valid;
        n_child_cnt  = r_child_cnt;
        if (is_dec) begin
            n_worst      = '0;
            n_slot       = '0;
            n_cand_valid = 1'b0;
            n_child_cnt  = '0;
        end else begin
            if (i_in.is_next_hop && r_child_cnt != COUNT_SAT) begin
                n_child_cnt = r_child_cnt + 1'b1;
            end
            if (!i_in.is_next_hop && !i_in.is_parent) begin
                n_worst      = INF_RANK;
                n_slot       = i_in.neighbor_id;
                n_cand_valid = 1'b1;
            end else if (i_in.is_parent && !i_in.is_preferred && !i_in.is_next_hop &&
                         i_in.parent_rank_usable && r_worst < INF_RANK &&
                         i_in.path_rank > r_worst) begin
                n_worst      = i_in.path_rank;
                n_slot       = i_in.neighbor_id;
                n_cand_valid = 1'b1;
            end
        end
    end

    // Build the result of a decision item
    assign n_victim_found = allow && r_cand_valid;
    assign n_victim_id    = n_victim_found ? r_slot : '0;
    assign n_children     = r_child_cnt;

    // Hold configuration and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc        <= INC_RESET;
            r_worst      <= '0;
            r_slot       <= '0;
            r_cand_valid <= 1'b0;
            r_child_cnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_inc <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_worst      <= n_worst;
                r_slot       <= n_slot;
                r_cand_valid <= n_cand_valid;
                r_child_cnt  <= n_child_cnt;
            end
        end
    end

    // Load the result register on a decision, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && is_dec) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && is_dec) begin
            r_victim_found <= n_victim_found;
            r_victim_id    <= n_victim_id;
            r_children     <= n_children;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.victim_found  = r_victim_found;
    assign o_out.victim_id     = r_victim_id;
    assign o_out.children_seen = r_children;

    // A candidate always carries a nonzero worst rank, and none leaves state clear
    a_cand_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cand_valid |-> (r_worst != '0))
        else $error("candidate held with zero worst rank");

    a_no_cand_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cand_valid |-> (r_worst == '0 && r_slot == '0))
        else $error("stale candidate data without a candidate");

    // A decision clears the scan
    a_dec_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_dec) |=> (r_child_cnt == '0 && !r_cand_valid))
        else $error("scan state not cleared after decision");

    // A held, stalled result blocks new items
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while result register is stalled");

    // A result without a victim reports slot zero
    a_no_victim_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_victim_found) |-> (r_victim_id == '0))
        else $error("victim id set without a victim");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for neighbor_eviction_policy: streams neighbor scans
// and decision items, predicts each eviction verdict and compares every result.
// Depends on nep_pkg, nep_in_if, nep_out_if and the neighbor_eviction_policy RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import nep_pkg::*;

    localparam int LIMIT_CYCLES = 200000;

    typedef struct {
        t_req  req;
        t_id   id;
        logic  child;
        logic  parent;
        logic  pref;
        logic  usable;
        t_rank path_rank;
        t_rank new_rank;
        logic  known;
        logic  root;
    } t_nb_item;

    typedef struct {
        logic   found;
        t_id    victim;
        t_count children;
    } t_verdict;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_cfg_we;
    t_rank i_cfg_wdata;

    nep_in_if  in_ch();
    nep_out_if res_ch();

    neighbor_eviction_policy u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (res_ch)
    );

    // Predicted scan state and register copy
    t_rank  hop_inc;
    t_rank  scan_worst_rank;
    t_id    scan_cand_id;
    logic   scan_cand_ok;
    t_count scan_children;

    t_verdict verdicts_due[$];

    int errors;
    int cycles;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold;
    int child_pct;

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Abort a hung run
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("neighbor_eviction_policy verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Fold one entry into the predicted scan state
    task automatic apply_entry(input t_nb_item it);
        if (it.child && scan_children != COUNT_SAT)
            scan_children++;
        if (it.parent && !it.pref && !it.child && it.usable &&
            scan_worst_rank < INF_RANK && it.path_rank > scan_worst_rank) begin
            scan_worst_rank = it.path_rank;
            scan_cand_id    = it.id;
            scan_cand_ok    = 1'b1;
        end
        if (!it.child && !it.parent) begin
            scan_worst_rank = INF_RANK;
            scan_cand_id    = it.id;
            scan_cand_ok    = 1'b1;
        end
    endtask

    // Close the scan: work out the verdict and clear the scan state
    task automatic decide_eviction(input t_nb_item it);
        t_verdict v;
        logic     allow;
        int       lhs;
        int       rhs;
        allow = 1'b0;
        case (it.req)
            REQ_DIS: begin
                allow = int'(scan_children) < MAX_NEIGHBORS - 2;
            end
            REQ_DIO: begin
                lhs = int'(it.new_rank) + int'(hop_inc);
                rhs = int'(scan_worst_rank) - int'(hop_inc) / 2;
                allow = it.known && (lhs < rhs);
            end
            default: begin
                allow = int'(scan_children) <
                        (it.root ? MAX_NEIGHBORS : MAX_NEIGHBORS - 2);
            end
        endcase
        allow      = allow && scan_cand_ok;
        v.found    = allow;
        v.victim   = allow ? scan_cand_id : t_id'(0);
        v.children = scan_children;
        verdicts_due.push_back(v);
        scan_worst_rank = '0;
        scan_cand_id    = '0;
        scan_cand_ok    = 1'b0;
        scan_children   = '0;
    endtask

    // Offer one item, hold it until accepted, then predict. Starts and ends at negedge.
    task automatic send_item(input t_nb_item it);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.req_type           = it.req;
        in_ch.neighbor_id        = it.id;
        in_ch.is_next_hop        = it.child;
        in_ch.is_parent          = it.parent;
        in_ch.is_preferred       = it.pref;
        in_ch.parent_rank_usable = it.usable;
        in_ch.path_rank          = it.path_rank;
        in_ch.new_rank           = it.new_rank;
        in_ch.instance_known     = it.known;
        in_ch.node_is_root       = it.root;
        in_ch.valid              = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        if (it.req == REQ_ENTRY)
            apply_entry(it);
        else
            decide_eviction(it);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every predicted verdict has arrived
    task automatic wait_drain();
        in_ch.valid = 1'b0;
        while (verdicts_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write the hop increment register; only called with the block idle
    task automatic write_hop_inc(input t_rank value);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(posedge i_clk);
        hop_inc = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic t_nb_item mk(input t_req req, input int id, input bit child,
                                    input bit parent, input bit pref, input bit usable,
                                    input int path_rank, input int new_rank,
                                    input bit known, input bit root);
        t_nb_item it;
        it.req       = req;
        it.id        = t_id'(id);
        it.child     = child;
        it.parent    = parent;
        it.pref      = pref;
        it.usable    = usable;
        it.path_rank = t_rank'(path_rank);
        it.new_rank  = t_rank'(new_rank);
        it.known     = known;
        it.root      = root;
        return it;
    endfunction

    function automatic t_nb_item rand_entry();
        t_nb_item it;
        it.req       = REQ_ENTRY;
        it.id        = t_id'($urandom);
        it.child     = ($urandom_range(99) < child_pct);
        it.parent    = ($urandom_range(99) < 70);
        it.pref      = ($urandom_range(99) < 25);
        it.usable    = ($urandom_range(99) < 80);
        it.path_rank = $urandom_range(1) ? t_rank'($urandom) : t_rank'($urandom_range(0, 600));
        it.new_rank  = t_rank'($urandom);
        it.known     = 1'($urandom_range(1));
        it.root      = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic t_nb_item rand_decision();
        t_nb_item it;
        it.req       = t_req'($urandom_range(1, 3));
        it.id        = t_id'($urandom);
        it.child     = 1'($urandom_range(1));
        it.parent    = 1'($urandom_range(1));
        it.pref      = 1'($urandom_range(1));
        it.usable    = 1'($urandom_range(1));
        it.path_rank = t_rank'($urandom);
        it.new_rank  = $urandom_range(1) ? t_rank'($urandom) : t_rank'($urandom_range(0, 2000));
        it.known     = ($urandom_range(99) < 80);
        it.root      = 1'($urandom_range(1));
        return it;
    endfunction

    // Random scans: mostly short, some long enough to cross the child caps and saturate
    task automatic run_scans(input int n_items);
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(9);
            if (pick == 0) begin
                len = $urandom_range(32, 40);
                child_pct = 95;
            end else if (pick == 1) begin
                len = $urandom_range(12, 18);
                child_pct = 85;
            end else begin
                len = $urandom_range(0, 10);
                child_pct = 30;
            end
            repeat (len) send_item(rand_entry());
            send_item(rand_decision());
            sent += len + 1;
        end
        wait_drain();
    endtask

    // Field extremes, every decision type and the DIO boundary
    task automatic test_directed();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // decisions with an empty scan
        send_item(mk(REQ_DIS, 15, 1, 1, 1, 1, 65535, 65535, 1, 1));
        send_item(mk(REQ_DIO, 0, 0, 0, 0, 0, 0, 0, 1, 0));
        send_item(mk(REQ_DAO, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        // neither child nor parent takes infinite rank
        send_item(mk(REQ_ENTRY, 0, 0, 0, 1, 1, 0, 65535, 0, 1));
        send_item(mk(REQ_DIO, 0, 0, 0, 0, 0, 0, 0, 1, 0));
        // top rank freezes the candidate
        send_item(mk(REQ_ENTRY, 15, 0, 1, 0, 1, 65535, 0, 0, 0));
        send_item(mk(REQ_ENTRY, 2, 0, 1, 0, 1, 65534, 0, 0, 0));
        send_item(mk(REQ_DIO, 0, 0, 0, 0, 0, 0, 65535, 1, 0));
        // preferred, child and unusable parents are never candidates
        send_item(mk(REQ_ENTRY, 7, 0, 1, 1, 1, 500, 0, 0, 0));
        send_item(mk(REQ_ENTRY, 8, 1, 1, 0, 1, 600, 0, 0, 0));
        send_item(mk(REQ_ENTRY, 9, 0, 1, 0, 0, 700, 0, 0, 0));
        send_item(mk(REQ_ENTRY, 10, 0, 1, 0, 1, 0, 0, 0, 0));
        send_item(mk(REQ_DIS, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // worst rank kept, unknown instance blocks DIO
        send_item(mk(REQ_ENTRY, 4, 0, 1, 0, 1, 1000, 0, 0, 0));
        send_item(mk(REQ_ENTRY, 6, 0, 1, 0, 1, 900, 0, 0, 0));
        send_item(mk(REQ_DIO, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // DIO compare right at the boundary
        send_item(mk(REQ_ENTRY, 11, 0, 1, 0, 1, 1000, 0, 0, 0));
        send_item(mk(REQ_DIO, 0, 0, 0, 0, 0, 0, 616, 1, 0));
        send_item(mk(REQ_ENTRY, 11, 0, 1, 0, 1, 1000, 0, 0, 0));
        send_item(mk(REQ_DIO, 0, 0, 0, 0, 0, 0, 615, 1, 0));
        // DAO off root, and a lone child gives no candidate
        send_item(mk(REQ_ENTRY, 3, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(REQ_DAO, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(REQ_ENTRY, 1, 1, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(REQ_DIS, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        wait_drain();
    endtask

    // Sender busy, receiver stalled for a long stretch, then a full drain
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        child_pct   = 30;
        rx_hold     = 80;
        repeat (20) begin
            send_item(rand_entry());
            send_item(rand_decision());
        end
        wait_drain();
    endtask

    // Random scans under one idle profile and two register settings
    task automatic test_random_phase(input int tx_pct, input int rx_pct,
                                     input t_rank inc_a, input t_rank inc_b);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        write_hop_inc(inc_a);
        run_scans(128);
        write_hop_inc(inc_b);
        run_scans(128);
    endtask

    // Compare each result with the oldest prediction
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (verdicts_due.size() == 0) begin
                report_mismatch("unexpected result, victim_id", int'(res_ch.victim_id), -1);
            end else begin
                want = verdicts_due.pop_front();
                if (res_ch.victim_found !== want.found)
                    report_mismatch("victim_found", int'(res_ch.victim_found),
                                    int'(want.found));
                if (res_ch.victim_id !== want.victim)
                    report_mismatch("victim_id", int'(res_ch.victim_id), int'(want.victim));
                if (res_ch.children_seen !== want.children)
                    report_mismatch("children_seen", int'(res_ch.children_seen),
                                    int'(want.children));
            end
        end
    end

    // Receiver: random stalls, or a counted hold-off when requested
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            res_ch.ready = 1'b0;
            rx_hold--;
        end else begin
            res_ch.ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        errors      = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold     = 0;
        child_pct   = 30;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        in_ch.valid              = 1'b0;
        in_ch.req_type           = REQ_ENTRY;
        in_ch.neighbor_id        = '0;
        in_ch.is_next_hop        = 1'b0;
        in_ch.is_parent          = 1'b0;
        in_ch.is_preferred       = 1'b0;
        in_ch.parent_rank_usable = 1'b0;
        in_ch.path_rank          = '0;
        in_ch.new_rank           = '0;
        in_ch.instance_known     = 1'b0;
        in_ch.node_is_root       = 1'b0;
        res_ch.ready             = 1'b0;
        hop_inc         = INC_RESET;
        scan_worst_rank = '0;
        scan_cand_id    = '0;
        scan_cand_ok    = 1'b0;
        scan_children   = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_backpressure();
        test_random_phase(21, 71, 16'd0, 16'd65535);
        test_random_phase(71, 21, 16'd1, t_rank'($urandom));
        test_random_phase(0, 0, 16'd2, INC_RESET);
        wait_drain();

        if (errors == 0)
            $display("neighbor_eviction_policy verification clean");
        else
            $display("neighbor_eviction_policy verification failed");
        $finish;
    end

endmodule
